// ===== rtl/rsh_pkg.sv =====
// ---------------------------------------------------------------------------
// rsh_pkg: shared types and constants of the radial smoothstep height block
// widths, register indices and the stage records passed along the cell chains
// ---------------------------------------------------------------------------
package rsh_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int RADIUS_W       = 31;
  localparam int PEAK_W         = 16;
  localparam int HEIGHT_W       = 24;
  localparam int FRAC_T         = 24;

  // root extraction works on a 64-bit radicand, two bits per cell
  localparam int SQRT_W         = 64;
  localparam int SQRT_STEPS     = 32;
  // one quotient bit per cell
  localparam int DIV_STEPS      = FRAC_T;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_HEIGHT = 2'd3;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd4194304;
  localparam logic [PEAK_W-1:0]   PEAK_RST   = 16'd100;

  typedef struct packed {
    logic              vld;
    logic              far;
    logic [SQRT_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sqrt_stage_t;

  typedef struct packed {
    logic                 vld;
    logic                 far;
    logic [RADIUS_W-1:0]  rem;
    logic [DIV_STEPS-1:0] quo;
  } div_stage_t;

endpackage

// ===== rtl/rsh_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// rsh_sqrt_cell: one step of the integer square root chain
// trial subtract at a fixed bit position, registered hand-off to the next cell
// ---------------------------------------------------------------------------
module rsh_sqrt_cell #(
  parameter int BIT_POS = 62
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  rsh_pkg::sqrt_stage_t prev,
  output rsh_pkg::sqrt_stage_t next
);

  localparam logic [rsh_pkg::SQRT_W-1:0] BIT_VAL = rsh_pkg::SQRT_W'(1) << BIT_POS;

  logic                        vld_r;
  logic                        far_r;
  logic [rsh_pkg::SQRT_W-1:0]  rem_r;
  logic [rsh_pkg::SQRT_W-1:0]  root_r;
  logic [rsh_pkg::SQRT_W-1:0]  trial;
  logic                        fits;

  assign trial = prev.root + BIT_VAL;
  assign fits  = prev.rem >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far_r  <= prev.far;
      rem_r  <= fits ? (prev.rem - trial) : prev.rem;
      root_r <= fits ? ((prev.root >> 1) + BIT_VAL) : (prev.root >> 1);
    end
  end

  assign next = '{vld: vld_r, far: far_r, rem: rem_r, root: root_r};

endmodule

// ===== rtl/rsh_div_cell.sv =====
// ---------------------------------------------------------------------------
// rsh_div_cell: one restoring division step
// shifts the partial remainder, subtracts the radius when it fits
// ---------------------------------------------------------------------------
module rsh_div_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [rsh_pkg::RADIUS_W-1:0]  radius,
  input  rsh_pkg::div_stage_t           prev,
  output rsh_pkg::div_stage_t           next
);

  logic                           vld_r;
  logic                           far_r;
  logic [rsh_pkg::RADIUS_W-1:0]   rem_r;
  logic [rsh_pkg::DIV_STEPS-1:0]  quo_r;
  logic [rsh_pkg::RADIUS_W:0]     rem2;
  logic [rsh_pkg::RADIUS_W:0]     diff;
  logic                           fits;

  assign rem2 = {prev.rem, 1'b0};
  assign diff = rem2 - {1'b0, radius};
  assign fits = rem2 >= {1'b0, radius};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far_r <= prev.far;
      rem_r <= fits ? diff[rsh_pkg::RADIUS_W-1:0] : rem2[rsh_pkg::RADIUS_W-1:0];
      quo_r <= {prev.quo[rsh_pkg::DIV_STEPS-2:0], fits};
    end
  end

  assign next = '{vld: vld_r, far: far_r, rem: rem_r, quo: quo_r};

endmodule

// ===== rtl/radial_smoothstep_height_top.sv =====
// ---------------------------------------------------------------------------
// radial_smoothstep_height_top: height of a round smoothstep hill
// distance to the centre, root and division chains, smoothstep and scaling
// ---------------------------------------------------------------------------
// One ground point is taken per transfer and one height comes out for it, in
// order. The block takes a new point every cycle while in_ready is high; a
// result passes through 3 front stages for offset, squares and sum, 32 root
// cells, 24 division cells, 4 smoothstep and scaling stages, then the output
// register. The output register has a skid stage behind it, so the pipeline
// keeps flowing for one more result after the consumer stalls; in_ready falls
// only while that skid stage is occupied. Points whose offset from the centre
// reaches the radius on either axis, or whose squared distance reaches the
// squared radius, give height 0. The squared radius is held in a register
// that follows a radius write in the next cycle. Configuration writes are
// meant for idle periods only.
// ---------------------------------------------------------------------------
module radial_smoothstep_height_top #(
  parameter int COORD_BITS = rsh_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [COORD_BITS-1:0]          in_x_coord,
  input  logic [COORD_BITS-1:0]          in_z_coord,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rsh_pkg::HEIGHT_W-1:0]   out_height,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [rsh_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [rsh_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAG_W  = (DIFF_W > rsh_pkg::RADIUS_W) ? DIFF_W : rsh_pkg::RADIUS_W;
  localparam int RW     = rsh_pkg::RADIUS_W;
  localparam int SQ_W   = 2 * RW;
  localparam int T_W    = rsh_pkg::FRAC_T;
  localparam logic [T_W+1:0] THREE = (T_W+2)'(3) << T_W;
  localparam logic [T_W+1:0] ONE   = (T_W+2)'(1) << T_W;

  // configuration registers
  logic [COORD_BITS-1:0]        center_x_r;
  logic [COORD_BITS-1:0]        center_z_r;
  logic [RW-1:0]                radius_r;
  logic [rsh_pkg::PEAK_W-1:0]   peak_r;
  logic [SQ_W-1:0]              radius_sq_r;
  logic [COORD_BITS+rsh_pkg::CFG_W-1:0] cfg_ext;

  assign cfg_ext = {{COORD_BITS{1'b0}}, cfg_wdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_z_r <= '0;
      radius_r   <= rsh_pkg::RADIUS_RST;
      peak_r     <= rsh_pkg::PEAK_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rsh_pkg::REG_CENTER_X:    center_x_r <= cfg_ext[COORD_BITS-1:0];
        rsh_pkg::REG_CENTER_Z:    center_z_r <= cfg_ext[COORD_BITS-1:0];
        rsh_pkg::REG_RADIUS:      radius_r   <= cfg_wdata[RW-1:0];
        rsh_pkg::REG_PEAK_HEIGHT: peak_r     <= cfg_wdata[rsh_pkg::PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // squared radius for the far test, derived from the radius register
  always_ff @(posedge clk) begin
    radius_sq_r <= radius_r * radius_r;
  end

  // whole pipeline moves while the skid stage is empty
  logic en;
  logic skid_vld_r;
  assign en       = !skid_vld_r;
  assign in_ready = en;

  // stage 1: offsets and magnitudes
  logic signed [DIFF_W-1:0] dx, dz;
  logic [DIFF_W-1:0]        ax_r, az_r;
  logic                     s1_vld_r;

  assign dx = $signed({in_x_coord[COORD_BITS-1], in_x_coord})
            - $signed({center_x_r[COORD_BITS-1], center_x_r});
  assign dz = $signed({in_z_coord[COORD_BITS-1], in_z_coord})
            - $signed({center_z_r[COORD_BITS-1], center_z_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      az_r <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
    end
  end

  // stage 2: per-axis far test and squares
  logic [MAG_W-1:0] ax_ext, az_ext, r_ext;
  logic [SQ_W-1:0]  sqx_r, sqz_r;
  logic             s2_vld_r, s2_far_r;

  assign ax_ext = MAG_W'(ax_r);
  assign az_ext = MAG_W'(az_r);
  assign r_ext  = MAG_W'(radius_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_far_r <= (ax_ext >= r_ext) || (az_ext >= r_ext);
      sqx_r    <= ax_ext[RW-1:0] * ax_ext[RW-1:0];
      sqz_r    <= az_ext[RW-1:0] * az_ext[RW-1:0];
    end
  end

  // stage 3: squared distance and the radial far test
  logic [SQ_W:0]              d2;
  logic [rsh_pkg::SQRT_W-1:0] d2_r;
  logic                       s3_vld_r, s3_far_r;

  assign d2 = {1'b0, sqx_r} + {1'b0, sqz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_far_r <= s2_far_r || (d2 >= {1'b0, radius_sq_r});
      d2_r     <= rsh_pkg::SQRT_W'(d2);
    end
  end

  // root chain: two radicand bits per cell
  rsh_pkg::sqrt_stage_t sq_link [0:rsh_pkg::SQRT_STEPS];

  assign sq_link[0] = '{vld: s3_vld_r, far: s3_far_r, rem: d2_r, root: '0};

  for (genvar k = 0; k < rsh_pkg::SQRT_STEPS; k++) begin : g_sqrt
    rsh_sqrt_cell #(
      .BIT_POS(rsh_pkg::SQRT_W - 2 - 2 * k)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .prev (sq_link[k]),
      .next (sq_link[k+1])
    );
  end

  // division chain: distance over radius, one quotient bit per cell
  rsh_pkg::div_stage_t div_link [0:rsh_pkg::DIV_STEPS];

  assign div_link[0] = '{vld:  sq_link[rsh_pkg::SQRT_STEPS].vld,
                         far:  sq_link[rsh_pkg::SQRT_STEPS].far,
                         rem:  sq_link[rsh_pkg::SQRT_STEPS].root[RW-1:0],
                         quo:  '0};

  for (genvar k = 0; k < rsh_pkg::DIV_STEPS; k++) begin : g_div
    rsh_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .radius(radius_r),
      .prev  (div_link[k]),
      .next  (div_link[k+1])
    );
  end

  // smoothstep and scaling stages
  logic [T_W-1:0]     t;
  logic [2*T_W-1:0]   t_sq;
  logic [T_W-1:0]     t2_r;
  logic [T_W+1:0]     fac_r;
  logic [2*T_W+1:0]   prod;
  logic [T_W+1:0]     s_r;
  logic [T_W+1:0]     s_cap;
  logic [T_W+1:0]     rem_full;
  logic [T_W:0]       rem_r;
  logic [rsh_pkg::PEAK_W+T_W:0] scaled;
  logic [rsh_pkg::HEIGHT_W-1:0] h_r;
  logic [3:0]         m_vld_r;
  logic [2:0]         m_far_r;

  assign t        = div_link[rsh_pkg::DIV_STEPS].quo;
  assign t_sq     = t * t;
  assign prod     = t2_r * fac_r;
  assign s_cap    = (s_r > ONE) ? ONE : s_r;
  assign rem_full = ONE - s_cap;
  assign scaled   = peak_r * rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= '0;
    end else if (en) begin
      m_vld_r <= {m_vld_r[2:0], div_link[rsh_pkg::DIV_STEPS].vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_far_r <= {m_far_r[1:0], div_link[rsh_pkg::DIV_STEPS].far};
      t2_r    <= t_sq[2*T_W-1:T_W];
      fac_r   <= THREE - {1'b0, t, 1'b0};
      s_r     <= prod[2*T_W+1:T_W];
      // capped smoothstep keeps the remainder within one
      rem_r   <= rem_full[T_W:0];
      // out of range points carry height zero
      h_r     <= m_far_r[2] ? '0 : scaled[16 +: rsh_pkg::HEIGHT_W];
    end
  end

  // output register with skid stage
  logic                         out_vld_r;
  logic [rsh_pkg::HEIGHT_W-1:0] out_h_r;
  logic [rsh_pkg::HEIGHT_W-1:0] skid_h_r;
  logic                         out_free;

  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_free) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (m_vld_r[3]) begin
      if (out_free) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_free) begin
        out_h_r <= skid_h_r;
      end
    end else if (m_vld_r[3]) begin
      if (out_free) begin
        out_h_r <= h_r;
      end else begin
        skid_h_r <= h_r;
      end
    end
  end

  assign out_valid  = out_vld_r;
  assign out_height = out_h_r;

endmodule

// ===== rtl/rsh_checker.sv =====
// ---------------------------------------------------------------------------
// rsh_checker: port-level checks of the radial smoothstep height block
// bound to the top level
// ---------------------------------------------------------------------------
module rsh_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rsh_pkg::HEIGHT_W-1:0] out_height
);

  localparam logic [rsh_pkg::HEIGHT_W-1:0] HEIGHT_MAX = 24'd16776960;

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // input only stalls when a result is already waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no waiting result");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height))
    else $error("waiting result lost or changed");

  // peak times one never exceeds the top of the range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_height <= HEIGHT_MAX)
    else $error("height out of range");

endmodule

bind radial_smoothstep_height_top rsh_checker u_rsh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_height(out_height)
);
